[rtl/weighted_random_selector_unit_defines.svh]
// ----------------------------------------------------------------------------
// Weighted random selector unit: assertion macros
// Concurrent assertion wrappers shared by the selector's RTL files.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_RANDOM_SELECTOR_UNIT_DEFINES_SVH
`define WEIGHTED_RANDOM_SELECTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define WRS_ASSERT(lbl, ck, rst_n, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) \
	else $error("weighted_random_selector_unit: assertion failed");

// Expression must never be true outside reset.
`define WRS_ASSERT_NEVER(lbl, ck, rst_n, expr) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) !(expr)) \
	else $error("weighted_random_selector_unit: forbidden condition seen");

`else

`define WRS_ASSERT(lbl, ck, rst_n, prop)
`define WRS_ASSERT_NEVER(lbl, ck, rst_n, expr)

`endif

`endif

[rtl/wrs_pkg.sv]
// ----------------------------------------------------------------------------
// Weighted random selector: package
// Payload types, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package wrs_pkg;

	// Default configuration
	localparam int MAX_ENTRIES_DEF  = 8;
	localparam int WEIGHT_BITS_DEF  = 16;

	// Fixed field widths
	localparam int MODE_BITS        = 2;
	localparam int RND_BITS         = 16;
	localparam int OUTCOME_BITS     = 2;
	localparam int STATUS_BITS      = 3;
	localparam int INDEX_BITS       = 3;
	localparam int COUNT_BITS       = 4;
	localparam int CFG_INDEX_BITS   = 2;
	localparam int CFG_DATA_BITS    = 64;
	localparam int WEIGHT_FIELD     = 16;
	localparam int ENTRIES_PER_WORD = CFG_DATA_BITS / WEIGHT_FIELD;

	// Register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_ENTRY_COUNT  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WEIGHTS_LOW  = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WEIGHTS_HIGH = 2'd2;

	// Request modes
	localparam logic [MODE_BITS-1:0] MODE_PICK   = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_REPORT = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_ABORT  = 2'd2;

	// Outcomes
	localparam logic [OUTCOME_BITS-1:0] OC_RUNNING  = 2'd0;
	localparam logic [OUTCOME_BITS-1:0] OC_SUCCESS  = 2'd1;
	localparam logic [OUTCOME_BITS-1:0] OC_FAILURE  = 2'd2;
	localparam logic [OUTCOME_BITS-1:0] OC_RESERVED = 2'd3;

	// Result status codes
	localparam logic [STATUS_BITS-1:0] ST_PICKED      = 3'd0;
	localparam logic [STATUS_BITS-1:0] ST_NO_ENTRIES  = 3'd1;
	localparam logic [STATUS_BITS-1:0] ST_ZERO_WEIGHT = 3'd2;
	localparam logic [STATUS_BITS-1:0] ST_REPORTED    = 3'd3;
	localparam logic [STATUS_BITS-1:0] ST_ABORTED     = 3'd4;
	localparam logic [STATUS_BITS-1:0] ST_NO_ABORT    = 3'd5;

	typedef struct packed {
		logic [MODE_BITS-1:0]    mode;
		logic [RND_BITS-1:0]     random_fraction;
		logic [OUTCOME_BITS-1:0] entry_outcome;
	} req_t;

	typedef struct packed {
		logic [STATUS_BITS-1:0]  status;
		logic [INDEX_BITS-1:0]   entry_index;
		logic [OUTCOME_BITS-1:0] outcome;
	} rsp_t;

	// Kind of result the datapath forms on an emit command
	typedef enum logic [2:0] {
		EK_NO_ENTRIES,
		EK_HELD,
		EK_ZERO,
		EK_DRAW,
		EK_REPORT,
		EK_ABORT
	} emit_kind_t;

	typedef struct packed {
		logic       load_req;
		logic       clr_scan;
		logic       sum_step;
		logic       load_thr;
		logic       scan_step;
		logic       emit;
		emit_kind_t emit_kind;
	} dp_cmd_t;

	typedef struct packed {
		logic [MODE_BITS-1:0] mode;
		logic                 n_zero;
		logic                 run_hit;
		logic                 last;
		logic                 total_zero;
		logic                 scan_hit;
	} dp_sts_t;

endpackage

[rtl/weighted_random_selector_unit.sv]
// ----------------------------------------------------------------------------
// Weighted random selector unit
// Weighted lottery over up to MAX_ENTRIES entries with hold, report and abort.
// ----------------------------------------------------------------------------
// A request is taken at the clock edge where start is high and busy is low.
// Its result appears on result for one cycle with done high; the receiver
// must take it then, since the unit cannot be held off. Report, abort, a pick
// that returns the held entry and a pick with no entries are answered from
// the decode state alone. For a drawing pick over n entries in use, one
// shared adder walks the weights once to form the total and once more to
// find the threshold entry, with the threshold multiply state in between. A
// zero total ends the pick after the first pass. Configuration writes take
// effect at once; they are to be made only while the unit is idle, which the
// unit itself does not enforce.
// ----------------------------------------------------------------------------
module weighted_random_selector_unit #(
	parameter int MAX_ENTRIES = wrs_pkg::MAX_ENTRIES_DEF,
	parameter int WEIGHT_BITS = wrs_pkg::WEIGHT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [wrs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [wrs_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	input  logic                               start,
	input  wrs_pkg::req_t                      request,
	output logic                               busy,
	output logic                               done,
	output wrs_pkg::rsp_t                      result
);

	wrs_pkg::dp_cmd_t cmd;
	wrs_pkg::dp_sts_t sts;

	wrs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	wrs_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.request   (request),
		.cmd       (cmd),
		.sts       (sts),
		.done      (done),
		.result    (result)
	);

endmodule

[rtl/wrs_ctrl.sv]
// ----------------------------------------------------------------------------
// Weighted random selector: controller
// Sequences request decode, the weight sum pass and the threshold scan pass.
// ----------------------------------------------------------------------------
`include "weighted_random_selector_unit_defines.svh"

module wrs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  wrs_pkg::dp_sts_t  sts,
	output wrs_pkg::dp_cmd_t  cmd,
	output logic              busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SUM,
		S_MUL,
		S_SCAN
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load_req = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_IDLE;
				unique case (sts.mode)
					wrs_pkg::MODE_PICK: begin
						priority if (sts.n_zero) begin
							cmd.emit      = 1'b1;
							cmd.emit_kind = wrs_pkg::EK_NO_ENTRIES;
						end else if (sts.run_hit) begin
							cmd.emit      = 1'b1;
							cmd.emit_kind = wrs_pkg::EK_HELD;
						end else begin
							cmd.clr_scan = 1'b1;
							state_d      = S_SUM;
						end
					end
					wrs_pkg::MODE_REPORT: begin
						cmd.emit      = 1'b1;
						cmd.emit_kind = wrs_pkg::EK_REPORT;
					end
					wrs_pkg::MODE_ABORT: begin
						cmd.emit      = 1'b1;
						cmd.emit_kind = wrs_pkg::EK_ABORT;
					end
					// reserved mode: drop without a result
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_SUM: begin
				cmd.sum_step = 1'b1;
				if (sts.last) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				if (sts.total_zero) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = wrs_pkg::EK_ZERO;
					state_d       = S_IDLE;
				end else begin
					cmd.load_thr = 1'b1;
					state_d      = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_hit || sts.last) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = wrs_pkg::EK_DRAW;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`WRS_ASSERT(a_single_strobe, clk, arst_n, cmd.emit |=> !cmd.emit)
	`WRS_ASSERT(a_start_decodes, clk, arst_n, (start && !busy) |=> (state_q == S_DECODE))
	`WRS_ASSERT_NEVER(a_walk_nonempty, clk, arst_n, (state_q == S_SUM || state_q == S_SCAN) && sts.n_zero)

endmodule

[rtl/wrs_datapath.sv]
// ----------------------------------------------------------------------------
// Weighted random selector: datapath
// Configuration registers, selection state, shared weight adder, threshold
// multiplier and result register.
// ----------------------------------------------------------------------------
`include "weighted_random_selector_unit_defines.svh"

module wrs_datapath #(
	parameter int MAX_ENTRIES = wrs_pkg::MAX_ENTRIES_DEF,
	parameter int WEIGHT_BITS = wrs_pkg::WEIGHT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [wrs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [wrs_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
	input  wrs_pkg::req_t                        request,
	input  wrs_pkg::dp_cmd_t                     cmd,
	output wrs_pkg::dp_sts_t                     sts,
	output logic                                 done,
	output wrs_pkg::rsp_t                        result
);

	localparam int IDX_W  = $clog2(MAX_ENTRIES);
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int TOT_W  = WEIGHT_BITS + CNT_W;
	localparam int PROD_W = wrs_pkg::RND_BITS + TOT_W;

	// Configuration
	logic [wrs_pkg::COUNT_BITS-1:0] count_q;
	logic [WEIGHT_BITS-1:0]         weight_q [MAX_ENTRIES];

	// Selection state
	logic             running_valid_q;
	logic [IDX_W-1:0] running_index_q;
	logic             last_valid_q;
	logic [IDX_W-1:0] last_index_q;
	logic [IDX_W-1:0] chosen_q;
	logic             done_q;

	// Working registers
	wrs_pkg::req_t    req_q;
	logic [TOT_W-1:0] acc_q;
	logic [TOT_W-1:0] thr_q;
	logic [IDX_W-1:0] idx_q;
	wrs_pkg::rsp_t    result_q;

	logic [CNT_W-1:0]                  n;
	logic                              elig;
	logic [TOT_W-1:0]                  sum;
	logic [PROD_W-1:0]                 product;
	logic                              run_hit;
	logic                              scan_hit;
	logic [IDX_W-1:0]                  fallback_idx;
	logic [IDX_W-1:0]                  draw_idx;
	logic [wrs_pkg::OUTCOME_BITS-1:0]  oc_norm;
	wrs_pkg::rsp_t                     rsp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				weight_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				wrs_pkg::REG_ENTRY_COUNT: begin
					count_q <= cfg_wdata[wrs_pkg::COUNT_BITS-1:0];
				end
				wrs_pkg::REG_WEIGHTS_LOW: begin
					for (int i = 0; i < MAX_ENTRIES; i++) begin
						if (i < wrs_pkg::ENTRIES_PER_WORD) begin
							weight_q[i] <= cfg_wdata[(i % wrs_pkg::ENTRIES_PER_WORD) *
								wrs_pkg::WEIGHT_FIELD +: WEIGHT_BITS];
						end
					end
				end
				wrs_pkg::REG_WEIGHTS_HIGH: begin
					for (int i = 0; i < MAX_ENTRIES; i++) begin
						if (i >= wrs_pkg::ENTRIES_PER_WORD) begin
							weight_q[i] <= cfg_wdata[(i % wrs_pkg::ENTRIES_PER_WORD) *
								wrs_pkg::WEIGHT_FIELD +: WEIGHT_BITS];
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Saturate the entry count
	assign n = (count_q > wrs_pkg::COUNT_BITS'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
		: count_q[CNT_W-1:0];

	// The entry served last sits out the draw when two or more are in use
	assign elig = !(last_valid_q && (n > CNT_W'(1)) && (last_index_q == idx_q));
	assign sum  = acc_q + (elig ? TOT_W'(weight_q[idx_q]) : '0);

	assign product  = PROD_W'(req_q.random_fraction) * PROD_W'(acc_q);
	assign run_hit  = running_valid_q && (CNT_W'(running_index_q) < n);
	assign scan_hit = elig && (sum >= thr_q);

	assign fallback_idx = (last_valid_q && (last_index_q == '0) && (n > CNT_W'(1)))
		? IDX_W'(1) : '0;
	assign draw_idx = scan_hit ? idx_q : fallback_idx;

	assign oc_norm = (req_q.entry_outcome == wrs_pkg::OC_RESERVED) ? wrs_pkg::OC_FAILURE
		: req_q.entry_outcome;

	always_comb begin
		sts            = '0;
		sts.mode       = req_q.mode;
		sts.n_zero     = (n == '0);
		sts.run_hit    = run_hit;
		sts.last       = (CNT_W'(idx_q) == n - CNT_W'(1));
		sts.total_zero = (acc_q == '0);
		sts.scan_hit   = scan_hit;
	end

	always_comb begin
		rsp_d         = '0;
		rsp_d.outcome = wrs_pkg::OC_RUNNING;
		unique case (cmd.emit_kind)
			wrs_pkg::EK_NO_ENTRIES: begin
				rsp_d.status = wrs_pkg::ST_NO_ENTRIES;
			end
			wrs_pkg::EK_HELD: begin
				rsp_d.status      = wrs_pkg::ST_PICKED;
				rsp_d.entry_index = wrs_pkg::INDEX_BITS'(running_index_q);
			end
			wrs_pkg::EK_ZERO: begin
				rsp_d.status = wrs_pkg::ST_ZERO_WEIGHT;
			end
			wrs_pkg::EK_DRAW: begin
				rsp_d.status      = wrs_pkg::ST_PICKED;
				rsp_d.entry_index = wrs_pkg::INDEX_BITS'(draw_idx);
			end
			wrs_pkg::EK_REPORT: begin
				rsp_d.status      = wrs_pkg::ST_REPORTED;
				rsp_d.entry_index = wrs_pkg::INDEX_BITS'(chosen_q);
				rsp_d.outcome     = oc_norm;
			end
			wrs_pkg::EK_ABORT: begin
				if (run_hit) begin
					rsp_d.status      = wrs_pkg::ST_ABORTED;
					rsp_d.entry_index = wrs_pkg::INDEX_BITS'(running_index_q);
				end else begin
					rsp_d.status = wrs_pkg::ST_NO_ABORT;
				end
			end
			default: begin
				rsp_d.status = wrs_pkg::ST_NO_ABORT;
			end
		endcase
	end

	// Selection state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_valid_q <= 1'b0;
			running_index_q <= '0;
			last_valid_q    <= 1'b0;
			last_index_q    <= '0;
			chosen_q        <= '0;
			done_q          <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.emit) begin
				unique case (cmd.emit_kind)
					wrs_pkg::EK_HELD: begin
						chosen_q <= running_index_q;
					end
					wrs_pkg::EK_DRAW: begin
						chosen_q <= draw_idx;
					end
					wrs_pkg::EK_REPORT: begin
						if (oc_norm == wrs_pkg::OC_RUNNING) begin
							running_valid_q <= 1'b1;
							running_index_q <= chosen_q;
						end else begin
							running_valid_q <= 1'b0;
							last_valid_q    <= 1'b1;
							last_index_q    <= chosen_q;
						end
					end
					wrs_pkg::EK_ABORT: begin
						if (run_hit) begin
							running_valid_q <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Working registers and result payload
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= request;
		end
		if (cmd.clr_scan || cmd.load_thr) begin
			acc_q <= '0;
			idx_q <= '0;
		end else if (cmd.sum_step || cmd.scan_step) begin
			acc_q <= sum;
			idx_q <= idx_q + IDX_W'(1);
		end
		if (cmd.load_thr) begin
			thr_q <= product[wrs_pkg::RND_BITS +: TOT_W];
		end
		if (cmd.emit) begin
			result_q <= rsp_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`WRS_ASSERT(a_run_from_report, clk, arst_n, $rose(running_valid_q) |-> $past(cmd.emit && (cmd.emit_kind == wrs_pkg::EK_REPORT)))

endmodule

[tb/wrs_lottery_checker.sv]
// ----------------------------------------------------------------------------
// Weighted random selector: result checker
// Watches the configuration port and the request and result channels. It
// keeps its own copy of the registers and of the selector state, works out
// the result of every accepted request and compares each result, field by
// field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module wrs_lottery_checker
	import wrs_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
	input  logic                      start,
	input  req_t                      request,
	input  logic                      busy,
	input  logic                      done,
	input  rsp_t                      result,
	output int                        fail_count,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Register copies
	logic [COUNT_BITS-1:0]    cfg_count;
	logic [CFG_DATA_BITS-1:0] cfg_wlow;
	logic [CFG_DATA_BITS-1:0] cfg_whigh;

	// Selector state copies
	logic                  run_valid;
	logic [INDEX_BITS-1:0] run_idx;
	logic                  last_valid;
	logic [INDEX_BITS-1:0] last_idx;
	logic [INDEX_BITS-1:0] chosen_idx;

	rsp_t awaited_rsp[$];
	rsp_t want;
	rsp_t got_rsp;
	bit   has_rsp;

	task automatic report_mismatch(input string what, input int exp_v, input int got_v);
		$display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v,
			got_v);
		fail_count++;
	endtask

	function automatic int unsigned entries_in_use();
		return (cfg_count > MAX_ENTRIES) ? MAX_ENTRIES : cfg_count;
	endfunction

	function automatic logic [WEIGHT_FIELD-1:0] weight_at(input int unsigned i);
		logic [CFG_DATA_BITS-1:0] word;
		logic [WEIGHT_FIELD-1:0]  mask;
		word = (i < ENTRIES_PER_WORD) ? cfg_wlow : cfg_whigh;
		mask = '1;
		mask = mask >> (WEIGHT_FIELD - WEIGHT_BITS);
		return word[(i % ENTRIES_PER_WORD) * WEIGHT_FIELD +: WEIGHT_FIELD] & mask;
	endfunction

	// The entry served last sits out the draw once two or more are in use.
	function automatic bit eligible(input int unsigned i, input int unsigned n);
		return !(last_valid && n > 1 && i == last_idx);
	endfunction

	task automatic lottery_step(input req_t r, output bit has, output rsp_t rsp);
		int unsigned             n;
		int unsigned             i;
		logic [19:0]             total;
		logic [19:0]             cum;
		logic [35:0]             thr;
		logic [INDEX_BITS-1:0]   sel;
		bit                      found;
		logic [OUTCOME_BITS-1:0] oc;
		n = entries_in_use();
		has = 1'b1;
		rsp = '0;
		total = '0;
		cum = '0;
		sel = '0;
		found = 1'b0;
		case (r.mode)
			MODE_PICK: begin
				if (n == 0) begin
					rsp.status = ST_NO_ENTRIES;
				end else if (run_valid && run_idx < n) begin
					chosen_idx = run_idx;
					rsp.status = ST_PICKED;
					rsp.entry_index = chosen_idx;
				end else begin
					for (i = 0; i < n; i++)
						if (eligible(i, n))
							total = total + 20'(weight_at(i));
					if (total == 0) begin
						rsp.status = ST_ZERO_WEIGHT;
					end else begin
						thr = ({16'd0, total} * {20'd0, r.random_fraction}) >> 16;
						for (i = 0; i < n && !found; i++) begin
							if (eligible(i, n)) begin
								cum = cum + 20'(weight_at(i));
								if ({16'd0, cum} >= thr) begin
									sel = 3'(i);
									found = 1'b1;
								end
							end
						end
						// fall back when the scan reaches nothing
						if (!found)
							sel = (last_valid && last_idx == 0 && n > 1) ? 3'd1 : 3'd0;
						chosen_idx = sel;
						rsp.status = ST_PICKED;
						rsp.entry_index = chosen_idx;
					end
				end
			end
			MODE_REPORT: begin
				oc = (r.entry_outcome == OC_RESERVED) ? OC_FAILURE : r.entry_outcome;
				if (oc == OC_RUNNING) begin
					run_valid = 1'b1;
					run_idx = chosen_idx;
				end else begin
					run_valid = 1'b0;
					last_valid = 1'b1;
					last_idx = chosen_idx;
				end
				rsp.status = ST_REPORTED;
				rsp.entry_index = chosen_idx;
				rsp.outcome = oc;
			end
			MODE_ABORT: begin
				if (run_valid && run_idx < n) begin
					run_valid = 1'b0;
					rsp.status = ST_ABORTED;
					rsp.entry_index = run_idx;
				end else begin
					rsp.status = ST_NO_ABORT;
				end
			end
			default: begin
				has = 1'b0;
			end
		endcase
	endtask

	// Results come from requests taken at earlier edges: retire before accepting.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_count = '0;
			cfg_wlow = '0;
			cfg_whigh = '0;
			run_valid = 1'b0;
			run_idx = '0;
			last_valid = 1'b0;
			last_idx = '0;
			chosen_idx = '0;
			fail_count = 0;
			awaited_rsp.delete();
			pending = 0;
		end else begin
			if (done) begin
				got_rsp = result;
				if (awaited_rsp.size() == 0) begin
					report_mismatch("result with no transaction outstanding", 0,
						int'(got_rsp));
				end else begin
					want = awaited_rsp.pop_front();
					if (got_rsp.status !== want.status)
						report_mismatch("status", int'(want.status), int'(got_rsp.status));
					if (got_rsp.entry_index !== want.entry_index)
						report_mismatch("entry_index", int'(want.entry_index),
							int'(got_rsp.entry_index));
					if (got_rsp.outcome !== want.outcome)
						report_mismatch("outcome", int'(want.outcome), int'(got_rsp.outcome));
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_ENTRY_COUNT)
					cfg_count = cfg_wdata[COUNT_BITS-1:0];
				else if (cfg_index == REG_WEIGHTS_LOW)
					cfg_wlow = cfg_wdata;
				else if (cfg_index == REG_WEIGHTS_HIGH)
					cfg_whigh = cfg_wdata;
			end
			if (start && !busy) begin
				lottery_step(request, has_rsp, want);
				if (has_rsp)
					awaited_rsp = {awaited_rsp, want};
			end
			pending = awaited_rsp.size();
		end
	end

endmodule

[tb/tb_weighted_random_selector_unit.sv]
// ----------------------------------------------------------------------------
// Weighted random selector unit: testbench
// Drives pick, report, abort and reserved-mode requests through the command port under
// several register settings, first a directed run over the special cases,
// then random phases with and without sender gaps. A separate checker
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_weighted_random_selector_unit;
	import wrs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [MODE_BITS-1:0]      MODE_RESERVED = 2'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED    = 2'd3;
	localparam int                        SETTLE_CYCLES = 25;
	localparam int                        ITEMS_PER_SET = 40;
	// Time limit for the whole run of ~600 transactions
	localparam realtime                   LIMIT_NS      = 2_000_000;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_wdata;
	logic                      start;
	req_t                      request;
	logic                      busy;
	logic                      done;
	rsp_t                      result;
	int                        fail_count;
	int                        pending;
	int                        gap_pct;

	weighted_random_selector_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.start     (start),
		.request   (request),
		.busy      (busy),
		.done      (done),
		.result    (result)
	);

	wrs_lottery_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.start      (start),
		.request    (request),
		.busy       (busy),
		.done       (done),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#LIMIT_NS;
		$display("FAIL weighted_random_selector_unit");
		$finish;
	end

	function automatic req_t make_req(input logic [MODE_BITS-1:0] mode,
		input logic [RND_BITS-1:0] frac, input logic [OUTCOME_BITS-1:0] oc);
		req_t r;
		r.mode = mode;
		r.random_fraction = frac;
		r.entry_outcome = oc;
		return r;
	endfunction

	// Every task below is entered and left at a falling edge. Hold start
	// high after acceptance; the next task decides whether it drops.
	task automatic send_req(input req_t r);
		while ($urandom_range(99) < gap_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		request = r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		start = 1'b0;
		while (pending != 0)
			@(negedge clk);
		// a reserved-mode request may still keep the unit busy
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [CFG_DATA_BITS-1:0] rand_weights();
		logic [CFG_DATA_BITS-1:0] w;
		int                       k;
		w = {$urandom, $urandom};
		case ($urandom_range(4))
			0: w = '1;
			1: w = '0;
			2: for (k = 0; k < ENTRIES_PER_WORD; k++)
				w[k * WEIGHT_FIELD +: WEIGHT_FIELD] = 16'($urandom_range(15));
			3: for (k = 0; k < ENTRIES_PER_WORD; k++)
				if ($urandom_range(1))
					w[k * WEIGHT_FIELD +: WEIGHT_FIELD] = '0;
			default: ;
		endcase
		return w;
	endfunction

	function automatic logic [RND_BITS-1:0] rand_fraction();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic run_random(input int pct, input int target);
		int                       sent;
		int                       k;
		logic [CFG_DATA_BITS-1:0] cnt_word;
		logic [OUTCOME_BITS-1:0]  oc;
		req_t                     r;
		gap_pct = pct;
		sent = 0;
		while (sent < target) begin
			if (sent % ITEMS_PER_SET == 0) begin
				cnt_word = {$urandom, $urandom};
				cnt_word[COUNT_BITS-1:0] = ($urandom_range(4) == 0) ?
					4'($urandom_range(15)) : 4'($urandom_range(2, 8));
				write_reg(REG_ENTRY_COUNT, cnt_word);
				write_reg(REG_WEIGHTS_LOW, rand_weights());
				write_reg(REG_WEIGHTS_HIGH, rand_weights());
			end
			k = $urandom_range(99);
			if (k < 45) begin
				r = make_req(MODE_PICK, rand_fraction(), 2'($urandom));
			end else if (k < 82) begin
				k = $urandom_range(19);
				oc = (k < 6) ? OC_RUNNING : (k < 12) ? OC_SUCCESS :
					(k < 18) ? OC_FAILURE : OC_RESERVED;
				r = make_req(MODE_REPORT, 16'($urandom), oc);
			end else if (k < 92) begin
				r = make_req(MODE_ABORT, 16'($urandom), 2'($urandom));
			end else begin
				r = req_t'($urandom);
			end
			send_req(r);
			if (r.mode != MODE_RESERVED)
				sent++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		start = 1'b0;
		request = '0;
		gap_pct = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// no entries in use: report acts on entry 0, abort finds no held entry
		send_req(make_req(MODE_PICK, 16'hFFFF, OC_RESERVED));
		send_req(make_req(MODE_REPORT, 16'h0000, OC_RUNNING));
		send_req(make_req(MODE_PICK, 16'h1234, OC_RUNNING));
		send_req(make_req(MODE_ABORT, 16'h0000, OC_RUNNING));
		send_req(make_req(MODE_RESERVED, 16'hFFFF, OC_RESERVED));
		send_req(make_req(MODE_REPORT, 16'hFFFF, OC_RESERVED));

		// count saturates; only entry 7 carries weight
		write_reg(REG_ENTRY_COUNT, '1);
		write_reg(REG_WEIGHTS_LOW, '0);
		write_reg(REG_WEIGHTS_HIGH, 64'hFFFF_0000_0000_0000);
		write_reg(REG_UNUSED, {$urandom, $urandom});
		send_req(make_req(MODE_PICK, 16'h0000, OC_SUCCESS));
		send_req(make_req(MODE_PICK, 16'hFFFF, OC_SUCCESS));
		send_req(make_req(MODE_REPORT, 16'h0000, OC_RUNNING));
		send_req(make_req(MODE_PICK, 16'h0000, OC_RUNNING));

		// held entry now out of range, and nothing eligible has weight
		write_reg(REG_ENTRY_COUNT, 64'd3);
		send_req(make_req(MODE_PICK, 16'h8000, OC_RUNNING));
		send_req(make_req(MODE_ABORT, 16'h0000, OC_RUNNING));

		write_reg(REG_ENTRY_COUNT, 64'd8);
		send_req(make_req(MODE_ABORT, 16'h0000, OC_RUNNING));
		send_req(make_req(MODE_ABORT, 16'h0000, OC_RUNNING));
		write_reg(REG_WEIGHTS_LOW, '1);
		send_req(make_req(MODE_PICK, 16'h8000, OC_RUNNING));
		send_req(make_req(MODE_REPORT, 16'h0000, OC_SUCCESS));
		send_req(make_req(MODE_PICK, 16'hFFFF, OC_RUNNING));
		send_req(make_req(MODE_REPORT, 16'h0000, OC_FAILURE));

		// single entry: the last served one stays eligible
		write_reg(REG_WEIGHTS_HIGH, '1);
		write_reg(REG_ENTRY_COUNT, 64'd1);
		send_req(make_req(MODE_PICK, 16'h0000, OC_RUNNING));
		send_req(make_req(MODE_REPORT, 16'h0000, OC_SUCCESS));
		send_req(make_req(MODE_PICK, 16'hFFFF, OC_RUNNING));

		run_random(34, 200);
		run_random(56, 200);
		run_random(0, 200);

		start = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASS weighted_random_selector_unit");
		else
			$display("FAIL weighted_random_selector_unit");
		$finish;
	end

endmodule
